FILE: src/tls_pkg.sv
`timescale 1ns / 1ps

package tls_pkg;

   localparam int TEMP_W        = 26;
   localparam int VALUE_W       = 34;
   localparam int KIND_W        = 4;
   localparam int CMD_W         = 3;
   localparam int FRAC_W        = 8;
   localparam int LOG_DEPTH_DEF = 10;

   // command codes
   localparam logic [CMD_W-1:0] CMD_STORE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_AVG   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MIN   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MAX   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DUMP  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_EXIT  = 3'd6;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_STORED = 4'd0;
   localparam logic [KIND_W-1:0] KIND_FULL   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_AVG    = 4'd2;
   localparam logic [KIND_W-1:0] KIND_MIN    = 4'd3;
   localparam logic [KIND_W-1:0] KIND_MAX    = 4'd4;
   localparam logic [KIND_W-1:0] KIND_NA     = 4'd5;
   localparam logic [KIND_W-1:0] KIND_COUNT  = 4'd6;
   localparam logic [KIND_W-1:0] KIND_ENTRY  = 4'd7;
   localparam logic [KIND_W-1:0] KIND_EXIT   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 4'd9;
   localparam logic [KIND_W-1:0] KIND_HALTED = 4'd10;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [TEMP_W-1:0] temperature;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_TEMP,
      SEL_AVG,
      SEL_MIN,
      SEL_MAX,
      SEL_COUNT,
      SEL_ENTRY
   } val_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic              latch_req;
      logic              do_store;
      logic              set_halt;
      logic              start_div;
      logic              clr_idx;
      logic              inc_idx;
      logic              load_rsp;
      logic [KIND_W-1:0] rsp_kind;
      val_sel_type       rsp_sel;
      logic              rsp_last;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             halted;
      logic             empty;
      logic             full;
      logic             div_done;
      logic             idx_last;
      logic             out_free;
   } stat_type;

endpackage

FILE: src/tls_ram.sv
`timescale 1ns / 1ps

module tls_ram #(
   parameter int  WIDTH  = 26,
   parameter int  DEPTH  = 10,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

FILE: src/tls_ctrl.sv
`timescale 1ns / 1ps

module tls_ctrl import tls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_AVG,
      ST_DUMP_RD,
      ST_DUMP_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      ctrl.rsp_sel = SEL_ZERO;
      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.latch_req = 1'b1;
               state_in       = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stat.halted && stat.cmd == CMD_AVG && !stat.empty) begin
               ctrl.start_div = 1'b1;
               state_in       = ST_DIV;
            end else if (stat.out_free) begin
               ctrl.load_rsp = 1'b1;
               ctrl.rsp_last = 1'b1;
               state_in      = ST_IDLE;
               if (stat.halted) begin
                  ctrl.rsp_kind = KIND_HALTED;
               end else begin
                  case (stat.cmd)
                     CMD_STORE: begin
                        if (stat.full) begin
                           ctrl.rsp_kind = KIND_FULL;
                        end else begin
                           ctrl.do_store = 1'b1;
                           ctrl.rsp_kind = KIND_STORED;
                           ctrl.rsp_sel  = SEL_TEMP;
                        end
                     end
                     CMD_AVG: begin
                        ctrl.rsp_kind = KIND_NA;
                     end
                     CMD_MIN: begin
                        ctrl.rsp_kind = stat.empty ? KIND_NA : KIND_MIN;
                        ctrl.rsp_sel  = stat.empty ? SEL_ZERO : SEL_MIN;
                     end
                     CMD_MAX: begin
                        ctrl.rsp_kind = stat.empty ? KIND_NA : KIND_MAX;
                        ctrl.rsp_sel  = stat.empty ? SEL_ZERO : SEL_MAX;
                     end
                     CMD_DUMP: begin
                        ctrl.rsp_kind = KIND_COUNT;
                        ctrl.rsp_sel  = SEL_COUNT;
                        ctrl.rsp_last = stat.empty;
                        ctrl.clr_idx  = 1'b1;
                        if (!stat.empty) begin
                           state_in = ST_DUMP_RD;
                        end
                     end
                     CMD_EXIT: begin
                        ctrl.set_halt = 1'b1;
                        ctrl.rsp_kind = KIND_EXIT;
                     end
                     default: begin
                        ctrl.rsp_kind = KIND_ERROR;
                     end
                  endcase
               end
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (stat.out_free) begin
               ctrl.load_rsp = 1'b1;
               ctrl.rsp_kind = KIND_AVG;
               ctrl.rsp_sel  = SEL_AVG;
               ctrl.rsp_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            // RAM read of the current index lands next cycle
            state_in = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (stat.out_free) begin
               ctrl.load_rsp = 1'b1;
               ctrl.rsp_kind = KIND_ENTRY;
               ctrl.rsp_sel  = SEL_ENTRY;
               ctrl.rsp_last = stat.idx_last;
               if (stat.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ctrl.inc_idx = 1'b1;
                  state_in     = ST_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/tls_dpath.sv
`timescale 1ns / 1ps

module tls_dpath import tls_pkg::*; #(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  ctrl_type ctrl,
   output stat_type stat
);

   localparam int COUNT_W = $clog2(LOG_DEPTH + 1);
   localparam int ADDR_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int SUM_W   = TEMP_W + COUNT_W;
   localparam int DIV_W   = SUM_W + FRAC_W;
   localparam int STEP_W  = $clog2(DIV_W + 1);

   logic [CMD_W-1:0]   cmd_ff;
   logic [TEMP_W-1:0]  temp_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [TEMP_W-1:0]  min_ff, min_in;
   logic [TEMP_W-1:0]  max_ff, max_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               halted_ff, halted_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [DIV_W-1:0]   quot_ff, quot_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [TEMP_W-1:0]  entry_data;
   logic [COUNT_W:0]   trial;
   logic               trial_ge;
   logic [VALUE_W-1:0] value_mux;

   tls_ram #(
      .WIDTH (TEMP_W),
      .DEPTH (LOG_DEPTH)
   ) u_log (
      .clock      (clock),
      .wr_en      (ctrl.do_store),
      .wr_addr    (count_ff[ADDR_W-1:0]),
      .wr_data    (temp_ff),
      .rd_addr    (idx_ff),
      .rd_data_ff (entry_data)
   );

   // restoring divider, one quotient bit per cycle
   assign trial    = {rem_ff, quot_ff[DIV_W-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   always_comb begin
      count_in  = count_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      halted_in = halted_ff | ctrl.set_halt;
      if (ctrl.do_store) begin
         count_in = count_ff + COUNT_W'(1);
         sum_in   = sum_ff + SUM_W'(temp_ff);
         if (count_ff == '0 || temp_ff < min_ff) begin
            min_in = temp_ff;
         end
         if (count_ff == '0 || temp_ff > max_ff) begin
            max_in = temp_ff;
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.clr_idx) begin
         idx_in = '0;
      end else if (ctrl.inc_idx) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (ctrl.start_div) begin
         quot_in = {sum_ff, {FRAC_W{1'b0}}};
         rem_in  = '0;
         step_in = STEP_W'(DIV_W);
      end else if (step_ff != '0) begin
         quot_in = {quot_ff[DIV_W-2:0], trial_ge};
         rem_in  = trial_ge ? COUNT_W'(trial - {1'b0, count_ff}) : trial[COUNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
      end
   end

   always_comb begin
      case (ctrl.rsp_sel)
         SEL_TEMP:  value_mux = VALUE_W'(temp_ff);
         SEL_AVG:   value_mux = quot_ff[VALUE_W-1:0];
         SEL_MIN:   value_mux = VALUE_W'(min_ff);
         SEL_MAX:   value_mux = VALUE_W'(max_ff);
         SEL_COUNT: value_mux = VALUE_W'(count_ff);
         SEL_ENTRY: value_mux = VALUE_W'(entry_data);
         default:   value_mux = '0;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (ctrl.load_rsp) begin
         rsp_in.kind  = ctrl.rsp_kind;
         rsp_in.value = value_mux;
         rsp_in.last  = ctrl.rsp_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         sum_ff       <= '0;
         halted_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         halted_ff    <= halted_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch_req) begin
         cmd_ff  <= req_data.cmd;
         temp_ff <= req_data.temperature;
      end
      idx_ff  <= idx_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      stat.cmd      = cmd_ff;
      stat.halted   = halted_ff;
      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff == COUNT_W'(LOG_DEPTH));
      stat.div_done = (step_ff == '0);
      stat.idx_last = ((COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff);
      stat.out_free = ~rsp_valid_ff | rsp_ready;
   end

endmodule

FILE: src/temperature_log_statistics_unit.sv
`timescale 1ns / 1ps
// One command at a time. Store, min, max, exit, error: result loaded once the output is free.
// Average: the sum with 8 fraction bits appended is divided by the count in the
// one-bit-per-cycle restoring divider, then the result is loaded once the output is free.
// Dump: the count first, then each entry in turn, read from the registered log RAM.
// Next command taken the cycle after the last result is loaded.
// Synchronous reset clears counters, min/max, sum and the halt flag; the log is not cleared.

module temperature_log_statistics_unit import tls_pkg::*; #(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_type ctrl;
   stat_type stat;

   tls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   tls_dpath #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctrl      (ctrl),
      .stat      (stat)
   );

endmodule
